/* rtl/c2p_pkg.sv */
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types, constants and the bit transpose for the 4-bitplane
// chunky-to-planar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

    // Field widths
    localparam int GroupW     = 64;
    localparam int RowW       = 9;
    localparam int ColW       = 5;
    localparam int WordW      = 16;
    localparam int AddrW      = 20;
    localparam int TopW       = 8;
    localparam int RowStrideW = 10;
    localparam int PlaneStrW  = 8;
    localparam int NumPlanes  = 4;
    localparam int PixW       = GroupW / WordW;

    // Configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 10;

    // Register reset values
    localparam logic [TopW-1:0]       TopOffsetRst   = TopW'(32);
    localparam logic [RowStrideW-1:0] RowStrideRst   = RowStrideW'(256);
    localparam logic [PlaneStrW-1:0]  PlaneStrideRst = PlaneStrW'(64);

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_TOP_OFFSET   = 2'd0,
        CFG_ROW_STRIDE   = 2'd1,
        CFG_PLANE_STRIDE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [GroupW-1:0] chunky_group;
        logic [RowW-1:0]   src_row;
        logic [ColW-1:0]   word_column;
    } t_c2p_in;

    typedef struct packed {
        logic [WordW-1:0] plane0_word;
        logic [WordW-1:0] plane1_word;
        logic [WordW-1:0] plane2_word;
        logic [WordW-1:0] plane3_word;
        logic [AddrW-1:0] plane0_address;
        logic [AddrW-1:0] plane1_address;
        logic [AddrW-1:0] plane2_address;
        logic [AddrW-1:0] plane3_address;
    } t_c2p_out;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [TopW-1:0]       top_offset;
        logic [RowStrideW-1:0] row_stride;
        logic [PlaneStrW-1:0]  plane_stride;
    } t_c2p_cfg;

    // Gather bit 'plane' of every pixel; pixel k from the right lands in bit k,
    // so the leftmost pixel (top nibble) ends up in bit 15.
    function automatic logic [WordW-1:0] plane_bits(
        input logic [GroupW-1:0] group,
        input int unsigned       plane
    );
        logic [WordW-1:0] w;
        w = '0;
        for (int k = 0; k < WordW; k++) begin
            w[k] = group[PixW*k + plane];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/c2p_cfg_regs.sv */
// ----------------------------------------------------------------------------
// c2p_cfg_regs
// Configuration register file: top offset, row stride and plane stride,
// written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_cfg_regs
    import c2p_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  wire logic [CfgIdxW-1:0]  i_idx,
    input  wire logic [CfgDataW-1:0] i_data,
    output t_c2p_cfg                 o_cfg
);

    t_c2p_cfg r_cfg;

    // Decode the index and update one register; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_offset   <= TopOffsetRst;
            r_cfg.row_stride   <= RowStrideRst;
            r_cfg.plane_stride <= PlaneStrideRst;
        end else if (i_wr) begin
            unique case (i_idx)
                CFG_TOP_OFFSET:   r_cfg.top_offset   <= i_data[TopW-1:0];
                CFG_ROW_STRIDE:   r_cfg.row_stride   <= i_data[RowStrideW-1:0];
                CFG_PLANE_STRIDE: r_cfg.plane_stride <= i_data[PlaneStrW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/c2p_datapath.sv */
// ----------------------------------------------------------------------------
// c2p_datapath
// Combinational transpose of one 16-pixel group into four bitplane words,
// and the destination byte address of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_datapath
    import c2p_pkg::*;
(
    input  t_c2p_in  i_item,
    input  t_c2p_cfg i_cfg,
    output t_c2p_out o_res
);

    localparam int SumW = RowStrideW;      // row + top fits in 10 bits
    localparam int OffW = PlaneStrW + 2;   // up to 3 * plane_stride

    logic [SumW-1:0]  row_sum;
    logic [AddrW-1:0] row_base;
    logic [AddrW-1:0] base;
    logic [OffW-1:0]  off1;
    logic [OffW-1:0]  off2;
    logic [OffW-1:0]  off3;

    // Transpose by wiring
    assign o_res.plane0_word = plane_bits(i_item.chunky_group, 0);
    assign o_res.plane1_word = plane_bits(i_item.chunky_group, 1);
    assign o_res.plane2_word = plane_bits(i_item.chunky_group, 2);
    assign o_res.plane3_word = plane_bits(i_item.chunky_group, 3);

    // Row base: (row + top) * row_stride, then the word column in bytes
    assign row_sum  = SumW'(i_item.src_row) + SumW'(i_cfg.top_offset);
    assign row_base = AddrW'(row_sum) * AddrW'(i_cfg.row_stride);
    assign base     = row_base + AddrW'({i_item.word_column, 1'b0});

    // Plane offsets by shift and add
    assign off1 = OffW'(i_cfg.plane_stride);
    assign off2 = OffW'({i_cfg.plane_stride, 1'b0});
    assign off3 = off1 + off2;

    assign o_res.plane0_address = base;
    assign o_res.plane1_address = base + AddrW'(off1);
    assign o_res.plane2_address = base + AddrW'(off2);
    assign o_res.plane3_address = base + AddrW'(off3);

endmodule

`default_nettype wire

/* rtl/chunky_to_planar_4bpp_top.sv */
// ----------------------------------------------------------------------------
// chunky_to_planar_4bpp_top
// Chunky-to-planar converter for four bitplanes with address generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_in and raise i_start; the group is taken at a clock edge
//   where i_start is high and o_busy is low. o_busy is low at all times after
//   the first cycle out of reset, so one group can be taken every clock.
//   Output: o_result_valid strobes for one cycle with o_result holding four
//   bitplane words and their byte addresses. The receiver must take it in
//   that cycle; there is no stall path.
//   Pipeline: the group passes through the input register, then the result
//   register. Throughput: one group
//   per clock, set by the single pass through the transpose wiring and the
//   10x10 stride multiplier between the two registers.
//   Configuration: write top offset (index 0), row stride (1) and plane
//   stride (2) through i_cfg_valid/o_cfg_ready while no group is in flight;
//   other indexes are ignored.
//   Reset: synchronous, active low. Clears the pipeline valids and loads the
//   register defaults (top 32, row stride 256, plane stride 64); both
//   channels open in the cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module chunky_to_planar_4bpp_top
    import c2p_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  t_c2p_in                  i_in,
    output logic                     o_busy,
    output logic                     o_result_valid,
    output t_c2p_out                 o_result,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    logic     r_ready;
    logic     r_in_valid;
    t_c2p_in  r_in;
    logic     r_out_valid;
    t_c2p_out r_out;
    t_c2p_out n_out;
    t_c2p_cfg cfg;
    logic     accept;

    assign accept = i_start && r_ready;

    c2p_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && r_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    c2p_datapath u_datapath (
        .i_item (r_in),
        .i_cfg  (cfg),
        .o_res  (n_out)
    );

    // Open both channels once out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    // Advance the two-stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept;
            r_out_valid <= r_in_valid;
        end
    end

    // Capture the input transfer and the finished result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_busy         = !r_ready;
    assign o_cfg_ready    = r_ready;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

/* rtl/c2p_checker.sv */
// ----------------------------------------------------------------------------
// c2p_checker
// Port-level checks for the chunky-to-planar converter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_checker
    import c2p_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_start,
    input wire t_c2p_in  i_in,
    input wire logic     o_busy,
    input wire logic     o_result_valid,
    input wire t_c2p_out o_result
);

    // Every accepted transfer yields one result, through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_result_valid)
        else $error("accepted group produced no result");

    // No result without an accepted transfer ahead of it through the input and result registers
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without a matching input transfer");

    // Leftmost pixel's plane bits land in bit 15 of each word
    a_leftmost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            (o_result.plane0_word[15] == $past(i_in.chunky_group[60], 2)) &&
            (o_result.plane3_word[15] == $past(i_in.chunky_group[63], 2)))
        else $error("transpose misplaced the leftmost pixel");

    // Input side opens in the cycle after reset release
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |=> !o_busy)
        else $error("block stays busy after reset");

endmodule

bind chunky_to_planar_4bpp_top c2p_checker u_c2p_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .i_in           (i_in),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
